// ----- hw/rtl/npb_pkg.sv -----
`timescale 1ns / 1ps

package npb_pkg;

  localparam int CHAR_BITS   = 5;
  localparam int NGRAM_LEN   = 4;
  localparam int WORD_BITS   = 64;
  localparam int STORE_WORDS = 16384;
  localparam int BYTE_BITS   = 8;
  localparam int MODE_BITS   = 2;
  localparam int OUT_BITS    = 64;
  localparam int QUEUE_DEPTH = 4;

  localparam int ADDR_BITS = $clog2(STORE_WORDS);
  localparam int POS_BITS  = $clog2(WORD_BITS);
  localparam int IDX_BITS  = ADDR_BITS + POS_BITS;
  localparam int GRAM_BITS = CHAR_BITS * NGRAM_LEN;
  localparam int SEEN_BITS = $clog2(NGRAM_LEN + 1);
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [MODE_BITS-1:0] MODE_TEXT  = MODE_BITS'(0);
  localparam logic [MODE_BITS-1:0] MODE_READ  = MODE_BITS'(1);
  localparam logic [MODE_BITS-1:0] MODE_CLEAR = MODE_BITS'(2);

  typedef enum logic [1:0] {
    OP_SET,
    OP_READ,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    op_kind_e               kind;
    logic [ADDR_BITS-1:0]   addr;
    logic [POS_BITS-1:0]    pos;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_req_t;

  // Wrap the n-gram value onto the store's bit range.
  function automatic logic [IDX_BITS-1:0] gram_to_bit(input logic [GRAM_BITS-1:0] gram);
    logic [GRAM_BITS+IDX_BITS-1:0] ext;
    ext = {{IDX_BITS{1'b0}}, gram};
    return ext[IDX_BITS-1:0];
  endfunction

endpackage

// ----- hw/rtl/npb_front.sv -----
`timescale 1ns / 1ps

module npb_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [npb_pkg::MODE_BITS-1:0]     mode_i,
  input  logic [npb_pkg::BYTE_BITS-1:0]     text_byte_i,
  input  logic                              start_of_file_i,
  input  logic [npb_pkg::ADDR_BITS-1:0]     word_index_i,
  input  logic                              queue_full_i,
  input  logic                              init_done_i,
  output npb_pkg::op_req_t                  push_o
);

  logic [npb_pkg::GRAM_BITS-1:0] gram_q, gram_d;
  logic [npb_pkg::SEEN_BITS-1:0] seen_q, seen_d;

  logic                                           accept;
  logic [npb_pkg::CHAR_BITS-1:0]                  ch;
  logic [npb_pkg::GRAM_BITS-1:0]                  base_gram;
  logic [npb_pkg::GRAM_BITS+npb_pkg::CHAR_BITS-1:0] shifted;
  logic [npb_pkg::GRAM_BITS-1:0]                  next_gram;
  logic [npb_pkg::SEEN_BITS-1:0]                  base_seen;
  logic [npb_pkg::SEEN_BITS-1:0]                  next_seen;
  logic [npb_pkg::IDX_BITS-1:0]                   bit_idx;

  assign in_ready_o = !queue_full_i && init_done_i;
  assign accept     = in_valid_i && in_ready_o;

  assign ch        = text_byte_i[npb_pkg::CHAR_BITS-1:0];
  assign base_gram = start_of_file_i ? '0 : gram_q;
  assign shifted   = {base_gram, ch};
  assign next_gram = shifted[npb_pkg::GRAM_BITS-1:0];
  assign base_seen = start_of_file_i ? '0 : seen_q;
  assign next_seen = (base_seen < npb_pkg::SEEN_BITS'(npb_pkg::NGRAM_LEN)) ?
                     base_seen + 1'b1 : base_seen;
  assign bit_idx   = npb_pkg::gram_to_bit(next_gram);

  always_comb begin
    gram_d           = gram_q;
    seen_d           = seen_q;
    push_o.valid     = 1'b0;
    push_o.op.kind   = npb_pkg::OP_READ;
    push_o.op.addr   = word_index_i;
    push_o.op.pos    = '0;
    unique case (mode_i)
      npb_pkg::MODE_TEXT: begin
        if (accept) begin
          gram_d = next_gram;
          seen_d = next_seen;
        end
        // push no op unless the register holds a full n-gram once this byte is in
        push_o.valid   = accept && (next_seen == npb_pkg::SEEN_BITS'(npb_pkg::NGRAM_LEN));
        push_o.op.kind = npb_pkg::OP_SET;
        push_o.op.addr = bit_idx[npb_pkg::IDX_BITS-1:npb_pkg::POS_BITS];
        push_o.op.pos  = bit_idx[npb_pkg::POS_BITS-1:0];
      end
      npb_pkg::MODE_READ: begin
        push_o.valid   = accept;
        push_o.op.kind = npb_pkg::OP_READ;
      end
      npb_pkg::MODE_CLEAR: begin
        push_o.valid   = accept;
        push_o.op.kind = npb_pkg::OP_CLEAR;
      end
      default: begin
        push_o.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gram_q <= '0;
      seen_q <= '0;
    end else begin
      gram_q <= gram_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ----- hw/rtl/npb_queue.sv -----
`timescale 1ns / 1ps

module npb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  npb_pkg::op_req_t push_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output npb_pkg::op_t     head_o
);

  npb_pkg::op_t                  slot_q [npb_pkg::QUEUE_DEPTH];
  logic [npb_pkg::QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [npb_pkg::QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [npb_pkg::QCNT_BITS-1:0] count_q, count_d;
  logic                          do_push;
  logic                          do_pop;

  assign full_o      = (count_q == npb_pkg::QCNT_BITS'(npb_pkg::QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = slot_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_i.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- hw/rtl/npb_back.sv -----
`timescale 1ns / 1ps

module npb_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            queue_not_empty_i,
  input  npb_pkg::op_t                    queue_head_i,
  output logic                            queue_pop_o,
  output logic                            init_done_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [npb_pkg::OUT_BITS-1:0]    out_word_o
);

  logic [npb_pkg::WORD_BITS-1:0] store_mem [npb_pkg::STORE_WORDS];

  logic                          s1_valid_q, s1_valid_d;
  npb_pkg::op_t                  s1_op_q;
  logic                          s2_valid_q, s2_valid_d;
  npb_pkg::op_t                  s2_op_q;
  logic [npb_pkg::WORD_BITS-1:0] rdata_q;
  logic                          fwd_valid_q, fwd_valid_d;
  logic [npb_pkg::ADDR_BITS-1:0] fwd_addr_q;
  logic [npb_pkg::WORD_BITS-1:0] fwd_data_q;
  logic                          out_valid_q, out_valid_d;
  logic [npb_pkg::OUT_BITS-1:0]  out_word_q;
  logic                          init_busy_q, init_busy_d;
  logic [npb_pkg::ADDR_BITS-1:0] init_addr_q, init_addr_d;

  logic                                       advance;
  logic                                       s2_is_read;
  logic [npb_pkg::WORD_BITS-1:0]              cur_word;
  logic [npb_pkg::WORD_BITS-1:0]              bit_mask;
  logic [npb_pkg::WORD_BITS-1:0]              new_word;
  logic                                       pipe_write;
  logic                                       mem_we;
  logic [npb_pkg::ADDR_BITS-1:0]              mem_waddr;
  logic [npb_pkg::WORD_BITS-1:0]              mem_wdata;
  logic                                       mem_re;
  logic                                       out_load;
  logic [npb_pkg::OUT_BITS+npb_pkg::WORD_BITS-1:0] out_ext;

  assign s2_is_read = (s2_op_q.kind == npb_pkg::OP_READ);
  // hold the whole pipe only while a read waits on a full output register
  assign advance    = !(s2_valid_q && s2_is_read && out_valid_q && !out_ready_i);
  assign queue_pop_o = !init_busy_q && advance && queue_not_empty_i;
  assign init_done_o = !init_busy_q;

  // forward the word written at the same edge as this op's read
  assign cur_word = (fwd_valid_q && fwd_addr_q == s2_op_q.addr) ? fwd_data_q : rdata_q;
  assign bit_mask = {{(npb_pkg::WORD_BITS-1){1'b0}}, 1'b1} << s2_op_q.pos;

  always_comb begin
    case (s2_op_q.kind)
      npb_pkg::OP_SET:   new_word = cur_word | bit_mask;
      npb_pkg::OP_CLEAR: new_word = '0;
      default:           new_word = cur_word;
    endcase
  end

  assign pipe_write = advance && s2_valid_q && !s2_is_read;
  assign mem_we     = init_busy_q || pipe_write;
  assign mem_waddr  = init_busy_q ? init_addr_q : s2_op_q.addr;
  assign mem_wdata  = init_busy_q ? '0 : new_word;
  assign mem_re     = advance && s1_valid_q;

  assign out_load = advance && s2_valid_q && s2_is_read;
  assign out_ext  = {{npb_pkg::OUT_BITS{1'b0}}, cur_word};

  always_comb begin
    s1_valid_d  = advance ? queue_pop_o : s1_valid_q;
    s2_valid_d  = advance ? s1_valid_q : s2_valid_q;
    fwd_valid_d = advance ? pipe_write : fwd_valid_q;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    init_busy_d = init_busy_q;
    init_addr_d = init_addr_q;
    if (init_busy_q) begin
      init_addr_d = init_addr_q + 1'b1;
      if (init_addr_q == npb_pkg::ADDR_BITS'(npb_pkg::STORE_WORDS - 1)) begin
        init_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_mem[s1_op_q.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_op_q    <= queue_head_i;
      s2_op_q    <= s1_op_q;
      fwd_addr_q <= s2_op_q.addr;
      fwd_data_q <= new_word;
    end
    if (out_load) begin
      out_word_q <= out_ext[npb_pkg::OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      init_busy_q <= 1'b1;
      init_addr_q <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      fwd_valid_q <= fwd_valid_d;
      out_valid_q <= out_valid_d;
      init_busy_q <= init_busy_d;
      init_addr_q <= init_addr_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ----- hw/rtl/ngram_presence_bitmap.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Lanes
// s_axis   in         tdata: text_byte, word_index; tuser: mode, start_of_file
// m_axis   out        tdata: bitmap_word (read results only)
//
// One request per cycle is taken while the queue has room and the clearing pass is
// done; each store update is a read-modify-write over a two-stage pipe around the
// one-read, one-write store, with write forwarding. A read result passes the queue,
// stages s1 and s2 and the output register before it shows on m_axis. After reset
// a clearing pass zeroes all 16384 store words, one word a cycle; s_axis_tready stays
// low until it ends. Output stalls hold the back pipe; a four-entry queue absorbs them.

module ngram_presence_bitmap (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // text_byte [7:0], word_index [21:8], zero [23:22]
  input  logic [2:0]  s_axis_tuser,   // mode [1:0], start_of_file [2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // bitmap_word [63:0]
);

  npb_pkg::op_req_t push;
  npb_pkg::op_t     head;
  logic             queue_full;
  logic             queue_not_empty;
  logic             queue_pop;
  logic             init_done;

  npb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .mode_i         (s_axis_tuser[1:0]),
    .text_byte_i    (s_axis_tdata[7:0]),
    .start_of_file_i(s_axis_tuser[2]),
    .word_index_i   (s_axis_tdata[21:8]),
    .queue_full_i   (queue_full),
    .init_done_i    (init_done),
    .push_o         (push)
  );

  npb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .not_empty_o(queue_not_empty),
    .head_o     (head)
  );

  npb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .queue_not_empty_i(queue_not_empty),
    .queue_head_i     (head),
    .queue_pop_o      (queue_pop),
    .init_done_o      (init_done),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_word_o       (m_axis_tdata)
  );

endmodule

// ----- hw/rtl/npb_checker.sv -----
`timescale 1ns / 1ps

module npb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [23:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  // the clearing pass must block requests right after reset
  a_ready_low_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("request taken during store clearing pass");

  a_no_result_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

  a_out_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("stalled result dropped");

  a_out_data_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind ngram_presence_bitmap npb_checker u_npb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ----- sim/npb_bitmap_checker.sv -----
`timescale 1ns / 1ps

module npb_bitmap_checker
  import npb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // text_byte [7:0], word_index [21:8], zero [23:22]
  input  logic [2:0]  s_axis_tuser,   // mode [1:0], start_of_file [2]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // bitmap_word [63:0]
  output int          errors_o,
  output int          pending_o,
  output int          reads_checked_o
);

  // Shadow of the presence store and the n-gram shift state
  logic [WORD_BITS-1:0] bitmap_shadow [STORE_WORDS];
  logic [GRAM_BITS-1:0] gram_shadow;
  int unsigned          seen_count;
  logic [OUT_BITS-1:0]  read_words_q [$];
  int                   error_count = 0;
  int                   read_count = 0;

  always @(posedge clk_i) begin
    logic [MODE_BITS-1:0] mode;
    logic [ADDR_BITS-1:0] addr;
    logic [CHAR_BITS-1:0] ch;
    logic [IDX_BITS-1:0]  bit_idx;
    logic [OUT_BITS-1:0]  want;
    if (!rst_ni) begin
      foreach (bitmap_shadow[i]) bitmap_shadow[i] = '0;
      gram_shadow = '0;
      seen_count  = 0;
      read_words_q.delete();
    end else begin
      // results first: a request taken at this edge cannot answer at this edge
      if (m_axis_tvalid && m_axis_tready) begin
        if (read_words_q.size() == 0) begin
          error_count++;
          $display("%0t: result with no read pending: expected none, actual %h",
                   $time, m_axis_tdata);
        end else begin
          want = read_words_q.pop_front();
          read_count++;
          if (m_axis_tdata !== want) begin
            error_count++;
            $display("%0t: bitmap_word mismatch: expected %h, actual %h",
                     $time, want, m_axis_tdata);
          end
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        mode = s_axis_tuser[MODE_BITS-1:0];
        addr = s_axis_tdata[BYTE_BITS +: ADDR_BITS];
        case (mode)
          MODE_TEXT: begin
            ch = s_axis_tdata[CHAR_BITS-1:0];
            if (s_axis_tuser[MODE_BITS]) begin
              gram_shadow = '0;
              seen_count  = 0;
            end
            // shift in the newest character, drop the oldest
            gram_shadow = GRAM_BITS'({gram_shadow, ch});
            if (seen_count < NGRAM_LEN) seen_count++;
            if (seen_count >= NGRAM_LEN) begin
              bit_idx = IDX_BITS'(gram_shadow);
              bitmap_shadow[bit_idx[IDX_BITS-1:POS_BITS]][bit_idx[POS_BITS-1:0]] = 1'b1;
            end
          end
          MODE_READ: begin
            read_words_q.push_back(OUT_BITS'(bitmap_shadow[addr]));
          end
          MODE_CLEAR: begin
            bitmap_shadow[addr] = '0;
          end
          default: begin
            // unused mode: no state change, no result
          end
        endcase
      end
    end
    errors_o        <= error_count;
    pending_o       <= read_words_q.size();
    reads_checked_o <= read_count;
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import npb_pkg::*;

  localparam logic [MODE_BITS-1:0] MODE_UNUSED = MODE_BITS'(3);

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_REQS  = 780;
  localparam int PRESSURE_AT  = 150;
  localparam int PRESSURE_LEN = 40;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // text_byte [7:0], word_index [21:8], zero [23:22]
  logic [2:0]  s_axis_tuser = '0;   // mode [1:0], start_of_file [2]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // bitmap_word [63:0]

  int          errors;
  int          pending;
  int          reads_checked;

  logic        calm = 1'b0;         // no idling on either side while set
  logic        pressure_go = 1'b0;
  logic        pressure_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  int          n_text = 0;
  int          n_files = 0;
  int          n_clears = 0;
  int          n_unused = 0;

  always #4 clk = ~clk;

  ngram_presence_bitmap u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  npb_bitmap_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .errors_o        (errors),
    .pending_o       (pending),
    .reads_checked_o (reads_checked)
  );

  // Small alphabet keeps the n-grams on a few dozen store words
  function automatic logic [CHAR_BITS-1:0] common_char();
    case ($urandom_range(3))
      0: return CHAR_BITS'(5'h00);
      1: return CHAR_BITS'(5'h0B);
      2: return CHAR_BITS'(5'h14);
      default: return CHAR_BITS'(5'h1F);
    endcase
  endfunction

  // Store word that holds the n-gram starting with c0, c1, c2
  function automatic logic [ADDR_BITS-1:0] gram_word(input logic [CHAR_BITS-1:0] c0,
                                                     input logic [CHAR_BITS-1:0] c1,
                                                     input logic [CHAR_BITS-1:0] c2);
    logic [GRAM_BITS-1:0] g;
    g = GRAM_BITS'({c0, c1, c2, {CHAR_BITS{1'b0}}});
    return ADDR_BITS'(IDX_BITS'(g) >> POS_BITS);
  endfunction

  function automatic logic [ADDR_BITS-1:0] common_word();
    return gram_word(common_char(), common_char(), common_char());
  endfunction

  task automatic send_req(input logic [MODE_BITS-1:0] mode, input logic [7:0] text,
                          input logic sof, input logic [ADDR_BITS-1:0] idx);
    int gap;
    if (!calm && $urandom_range(99) < 18) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, text};
    s_axis_tuser  <= {sof, mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    case (mode)
      MODE_TEXT: begin
        n_text++;
        if (sof) n_files++;
      end
      MODE_CLEAR: n_clears++;
      MODE_UNUSED: n_unused++;
      default: ;
    endcase
  endtask

  task automatic send_text(input logic [7:0] text, input logic sof);
    send_req(MODE_TEXT, text, sof, ADDR_BITS'($urandom));
  endtask

  task automatic send_op(input logic [MODE_BITS-1:0] mode, input logic [ADDR_BITS-1:0] idx);
    send_req(mode, 8'($urandom), 1'($urandom), idx);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(99) < 31) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("** ngram_presence_bitmap: FAILED **");
      $finish;
    end
  end

  initial begin
    int          i;
    int          len;
    int          r;
    logic        pressed;
    logic [7:0]  b;
    pressed = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty store at both ends of the address range
    send_op(MODE_READ, '0);
    send_op(MODE_READ, '1);
    // no start mark yet: bytes count from reset
    send_text(8'hFF, 1'b0);
    send_text(8'h00, 1'b0);
    send_text(8'hE0, 1'b0);
    send_text(8'h3F, 1'b0);
    send_op(MODE_UNUSED, gram_word(5'h1F, 5'h00, 5'h00));
    send_op(MODE_READ, gram_word(5'h1F, 5'h00, 5'h00));
    // short file sets nothing, and the start mark drops the old characters
    send_text(8'h21, 1'b1);
    send_text(8'h22, 1'b0);
    send_text(8'h23, 1'b0);
    send_op(MODE_READ, gram_word(5'h00, 5'h01, 5'h02));
    send_op(MODE_READ, gram_word(5'h1F, 5'h01, 5'h02));
    // full n-gram, then one more byte
    send_text(8'h41, 1'b1);
    send_text(8'h42, 1'b0);
    send_text(8'h43, 1'b0);
    send_text(8'h44, 1'b0);
    send_text(8'h45, 1'b0);
    send_op(MODE_READ, gram_word(5'h01, 5'h02, 5'h03));
    send_op(MODE_READ, gram_word(5'h02, 5'h03, 5'h04));
    send_op(MODE_CLEAR, gram_word(5'h01, 5'h02, 5'h03));
    send_op(MODE_READ, gram_word(5'h01, 5'h02, 5'h03));
    send_op(MODE_CLEAR, '1);
    send_op(MODE_READ, '1);

    i = 0;
    while (i < RANDOM_REQS) begin
      calm = (i >= 350 && i < 500);
      if (!pressed && i >= PRESSURE_AT) begin
        // hold the output long enough to back up the pipe and the queue
        pressed     = 1'b1;
        pressure_go = 1'b1;
        repeat (PRESSURE_LEN) send_op(MODE_READ, common_word());
        i += PRESSURE_LEN;
      end else begin
        r = $urandom_range(99);
        if (r < 55) begin
          len = $urandom_range(1, 10);
          for (int k = 0; k < len; k++) begin
            b = 8'($urandom);
            if ($urandom_range(99) < 85) b[CHAR_BITS-1:0] = common_char();
            // now and then continue the previous file without a start mark
            send_text(b, (k == 0) && ($urandom_range(9) != 0));
          end
          i += len;
        end else begin
          if (r < 80)      send_op(MODE_READ, common_word());
          else if (r < 86) send_op(MODE_READ, ADDR_BITS'($urandom));
          else if (r < 93) send_op(MODE_CLEAR, common_word());
          else if (r < 96) send_op(MODE_CLEAR, ADDR_BITS'($urandom));
          else             send_op(MODE_UNUSED, ADDR_BITS'($urandom));
          i++;
        end
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d text bytes over %0d marked files, %0d reads compared,",
             n_text, n_files, reads_checked);
    $display("%0d word clears and %0d requests in the unused mode", n_clears, n_unused);
    if (errors == 0 && pending == 0) begin
      $display("** ngram_presence_bitmap: PASSED **");
    end else begin
      $display("** ngram_presence_bitmap: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/npb_pkg.sv
hw/rtl/npb_front.sv
hw/rtl/npb_queue.sv
hw/rtl/npb_back.sv
hw/rtl/ngram_presence_bitmap.sv
hw/rtl/npb_checker.sv
sim/npb_bitmap_checker.sv
sim/testbench.sv
